// ----- rtl/core/s2cm_pkg.sv -----
// Shared constants and types of the scalar-to-color map unit.
package s2cm_pkg;

   localparam int SAMPLE_BITS   = 32;
   localparam int FRACTION_BITS = 16;
   localparam int RANGE_BITS    = 32;
   localparam int COLOR_BITS    = 24;
   localparam int CHAN_BITS     = 8;
   localparam int NUM_CHANS     = COLOR_BITS / CHAN_BITS;

   // sample - range_min is exact at this width
   localparam int DIFF_BITS  = ((SAMPLE_BITS > RANGE_BITS) ? SAMPLE_BITS : RANGE_BITS) + 1;
   localparam int NORM_BITS  = FRACTION_BITS + 1;
   localparam int HUE_BITS   = FRACTION_BITS + 3;
   localparam int PROD_BITS  = FRACTION_BITS + CHAN_BITS;
   localparam int SUM_BITS   = FRACTION_BITS + CHAN_BITS + 1;
   // accept to strobe: diff, magnitude, classify, divider, norm, color, round
   localparam int PIPE_DEPTH = FRACTION_BITS + 6;

   localparam logic [NORM_BITS-1:0] NORM_ONE  = {1'b1, {FRACTION_BITS{1'b0}}};
   localparam logic [SUM_BITS-1:0]  ROUND_HALF = SUM_BITS'(NORM_ONE >> 1);
   localparam logic [CHAN_BITS-1:0] CHAN_FULL = '1;
   localparam logic [CHAN_BITS-1:0] CHAN_NONE = '0;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_MIN      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_MAX      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RAINBOW_ENABLE = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RAINBOW_INVERT = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOW_COLOR      = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HIGH_COLOR     = 3'd5;

   localparam logic signed [RANGE_BITS-1:0] RANGE_MIN_RESET  = 32'sd0;
   localparam logic signed [RANGE_BITS-1:0] RANGE_MAX_RESET  = 32'sd65536;
   localparam logic [COLOR_BITS-1:0]        LOW_COLOR_RESET  = 24'h000000;
   localparam logic [COLOR_BITS-1:0]        HIGH_COLOR_RESET = 24'hFFFFFF;

   // hue ramp segments, in order of rising t
   localparam logic [2:0] SEG_MAGENTA_BLUE = 3'd0;
   localparam logic [2:0] SEG_BLUE_CYAN    = 3'd1;
   localparam logic [2:0] SEG_CYAN_GREEN   = 3'd2;
   localparam logic [2:0] SEG_GREEN_YELLOW = 3'd3;
   localparam logic [2:0] SEG_YELLOW_RED   = 3'd4;
   localparam logic [2:0] SEG_RED          = 3'd5;

   typedef enum logic [1:0] {
      NK_DIV,
      NK_ZERO,
      NK_ONE
   } norm_kind_type;

endpackage

// ----- rtl/core/scalar_to_color_map_unit.sv -----
// Scalar-to-color map unit: pipelined normalize, divide and color stages.
// Maps one signed sample per clock to an RGB color. A sample is taken on any edge where start
// is high and busy is low; busy is high only while reset is asserted. The color appears on
// rsp_red/green/blue with rsp_strobe once the sample has passed the rounding stage, one
// result per sample, in order; there is no back-pressure, so the receiver must take each
// word in the cycle it is shown. Pipeline depth is set by the restoring divider,
// one quotient bit per stage (FRACTION_BITS stages), plus six stages of difference, magnitude,
// range check, normalize select, color math and rounding. The csr port is always ready;
// registers feed the pipeline live, so write them only while no sample is in flight.
module scalar_to_color_map_unit
   import s2cm_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic signed [SAMPLE_BITS-1:0]    req_sample,
   output logic                             rsp_strobe,
   output logic [CHAN_BITS-1:0]             rsp_red,
   output logic [CHAN_BITS-1:0]             rsp_green,
   output logic [CHAN_BITS-1:0]             rsp_blue,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [CSR_DATA_BITS-1:0]         csr_data
);

   // ---------------- configuration registers ----------------
   logic signed [RANGE_BITS-1:0] range_min_ff;
   logic signed [RANGE_BITS-1:0] range_max_ff;
   logic                         rainbow_enable_ff;
   logic                         rainbow_invert_ff;
   logic [COLOR_BITS-1:0]        low_color_ff;
   logic [COLOR_BITS-1:0]        high_color_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff      <= RANGE_MIN_RESET;
         range_max_ff      <= RANGE_MAX_RESET;
         rainbow_enable_ff <= 1'b1;
         rainbow_invert_ff <= 1'b0;
         low_color_ff      <= LOW_COLOR_RESET;
         high_color_ff     <= HIGH_COLOR_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RANGE_MIN:      range_min_ff      <= csr_data[RANGE_BITS-1:0];
            CSR_RANGE_MAX:      range_max_ff      <= csr_data[RANGE_BITS-1:0];
            CSR_RAINBOW_ENABLE: rainbow_enable_ff <= csr_data[0];
            CSR_RAINBOW_INVERT: rainbow_invert_ff <= csr_data[0];
            CSR_LOW_COLOR:      low_color_ff      <= csr_data[COLOR_BITS-1:0];
            CSR_HIGH_COLOR:     high_color_ff     <= csr_data[COLOR_BITS-1:0];
            default: ;
         endcase
      end
   end

   // range span, refreshed every cycle; read by the pipeline from the classify stage on
   logic signed [DIFF_BITS-1:0] span_in;
   logic [DIFF_BITS-1:0]        span_mag_ff;
   logic                        span_neg_ff;
   logic                        span_zero_ff;

   assign span_in = DIFF_BITS'(range_max_ff) - DIFF_BITS'(range_min_ff);

   always_ff @(posedge clock) begin
      span_neg_ff  <= span_in[DIFF_BITS-1];
      span_zero_ff <= (span_in == '0);
      span_mag_ff  <= span_in[DIFF_BITS-1] ? DIFF_BITS'(-span_in) : DIFF_BITS'(span_in);
   end

   // ---------------- stage A: difference ----------------
   logic                        a_valid_in;
   logic                        a_valid_ff;
   logic signed [DIFF_BITS-1:0] a_diff_ff;

   assign busy       = reset;
   assign a_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
      a_diff_ff <= DIFF_BITS'(req_sample) - DIFF_BITS'(range_min_ff);
   end

   // ---------------- stage B: magnitude ----------------
   logic                 b_valid_ff;
   logic [DIFF_BITS-1:0] b_mag_ff;
   logic                 b_neg_ff;
   logic                 b_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_neg_ff  <= a_diff_ff[DIFF_BITS-1];
      b_zero_ff <= (a_diff_ff == '0);
      b_mag_ff  <= a_diff_ff[DIFF_BITS-1] ? DIFF_BITS'(-a_diff_ff) : DIFF_BITS'(a_diff_ff);
   end

   // ---------------- stage C: classify, divider entry ----------------
   logic                     div_valid_ff [FRACTION_BITS+1];
   logic [DIFF_BITS-1:0]     div_rem_ff   [FRACTION_BITS+1];
   logic [FRACTION_BITS-1:0] div_quo_ff   [FRACTION_BITS+1];
   norm_kind_type            div_kind_ff  [FRACTION_BITS+1];
   norm_kind_type            c_kind_in;

   always_comb begin
      priority if (span_zero_ff || b_zero_ff || (b_neg_ff != span_neg_ff)) begin
         c_kind_in = NK_ZERO;
      end else if (b_mag_ff >= span_mag_ff) begin
         c_kind_in = NK_ONE;
      end else begin
         c_kind_in = NK_DIV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff[0] <= 1'b0;
      end else begin
         div_valid_ff[0] <= b_valid_ff;
      end
      div_kind_ff[0] <= c_kind_in;
      div_rem_ff[0]  <= (c_kind_in == NK_DIV) ? b_mag_ff : '0;
      div_quo_ff[0]  <= '0;
   end

   // ---------------- restoring divider, one quotient bit per stage ----------------
   // remainder stays below the span, so the doubled value fits one extra bit
   for (genvar k = 0; k < FRACTION_BITS; k++) begin : g_div
      logic [DIFF_BITS:0] shifted;
      logic               take;

      assign shifted = {div_rem_ff[k], 1'b0};
      assign take    = (div_kind_ff[k] == NK_DIV) && (shifted >= {1'b0, span_mag_ff});

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[k+1] <= 1'b0;
         end else begin
            div_valid_ff[k+1] <= div_valid_ff[k];
         end
         div_kind_ff[k+1] <= div_kind_ff[k];
         div_rem_ff[k+1]  <= take ? DIFF_BITS'(shifted - {1'b0, span_mag_ff})
                                  : DIFF_BITS'(shifted);
         div_quo_ff[k+1]  <= {div_quo_ff[k][FRACTION_BITS-2:0], take};
      end
   end

   // ---------------- stage E: normalized value ----------------
   logic                 e_valid_ff;
   logic [NORM_BITS-1:0] e_norm_ff;
   logic [NORM_BITS-1:0] e_norm_in;

   always_comb begin
      unique case (div_kind_ff[FRACTION_BITS])
         NK_ZERO: e_norm_in = '0;
         NK_ONE:  e_norm_in = NORM_ONE;
         default: e_norm_in = {1'b0, div_quo_ff[FRACTION_BITS]};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= div_valid_ff[FRACTION_BITS];
      end
      e_norm_ff <= e_norm_in;
   end

   // ---------------- stage F: hue ramp and gradient products ----------------
   logic                     f_valid_ff;
   logic                     f_rainbow_ff;
   logic [NORM_BITS-1:0]     f_chan_ff    [NUM_CHANS];
   logic [PROD_BITS-1:0]     f_hi_prod_ff [NUM_CHANS];
   logic [PROD_BITS-1:0]     f_lo_prod_ff [NUM_CHANS];
   logic [NORM_BITS-1:0]     f_chan_in    [NUM_CHANS];
   logic [PROD_BITS-1:0]     f_hi_prod_in [NUM_CHANS];
   logic [PROD_BITS-1:0]     f_lo_prod_in [NUM_CHANS];
   logic [NORM_BITS-1:0]     hue_t;
   logic [NORM_BITS-1:0]     norm_rest;
   logic [HUE_BITS-1:0]      hue_p;
   logic [2:0]               hue_seg;
   logic [FRACTION_BITS-1:0] hue_q;
   logic [NORM_BITS-1:0]     hue_n;
   logic [CHAN_BITS-1:0]     lo_chan;
   logic [CHAN_BITS-1:0]     hi_chan;

   always_comb begin
      norm_rest = NORM_ONE - e_norm_ff;
      hue_t     = rainbow_invert_ff ? e_norm_ff : norm_rest;
      hue_p     = (HUE_BITS'(hue_t) << 2) + HUE_BITS'(hue_t);
      hue_seg   = hue_p[HUE_BITS-1:FRACTION_BITS];
      hue_q     = hue_p[FRACTION_BITS-1:0];
      hue_n     = hue_seg[0] ? {1'b0, hue_q} : NORM_ONE - NORM_BITS'(hue_q);
      unique case (hue_seg)
         SEG_MAGENTA_BLUE: begin
            f_chan_in[0] = hue_n;    f_chan_in[1] = '0;       f_chan_in[2] = NORM_ONE;
         end
         SEG_BLUE_CYAN: begin
            f_chan_in[0] = '0;       f_chan_in[1] = hue_n;    f_chan_in[2] = NORM_ONE;
         end
         SEG_CYAN_GREEN: begin
            f_chan_in[0] = '0;       f_chan_in[1] = NORM_ONE; f_chan_in[2] = hue_n;
         end
         SEG_GREEN_YELLOW: begin
            f_chan_in[0] = hue_n;    f_chan_in[1] = NORM_ONE; f_chan_in[2] = '0;
         end
         default: begin
            f_chan_in[0] = NORM_ONE; f_chan_in[1] = hue_n;    f_chan_in[2] = '0;
         end
      endcase
      for (int ch = 0; ch < NUM_CHANS; ch++) begin
         lo_chan          = low_color_ff[COLOR_BITS-1-CHAN_BITS*ch -: CHAN_BITS];
         hi_chan          = high_color_ff[COLOR_BITS-1-CHAN_BITS*ch -: CHAN_BITS];
         f_hi_prod_in[ch] = PROD_BITS'(hi_chan * e_norm_ff);
         f_lo_prod_in[ch] = PROD_BITS'(lo_chan * norm_rest);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= e_valid_ff;
      end
      f_rainbow_ff <= rainbow_enable_ff;
      f_chan_ff    <= f_chan_in;
      f_hi_prod_ff <= f_hi_prod_in;
      f_lo_prod_ff <= f_lo_prod_in;
   end

   // ---------------- stage G: scale to 8 bits with rounding ----------------
   logic                 g_valid_ff;
   logic                 g_rainbow_ff;
   logic [CHAN_BITS-1:0] g_chan_ff [NUM_CHANS];
   logic [CHAN_BITS-1:0] g_chan_in [NUM_CHANS];
   logic [SUM_BITS-1:0]  round_sum;

   always_comb begin
      for (int ch = 0; ch < NUM_CHANS; ch++) begin
         if (f_rainbow_ff) begin
            // c * 255 as (c << 8) - c
            round_sum = (SUM_BITS'(f_chan_ff[ch]) << CHAN_BITS) - SUM_BITS'(f_chan_ff[ch])
                        + ROUND_HALF;
         end else begin
            round_sum = SUM_BITS'(f_hi_prod_ff[ch]) + SUM_BITS'(f_lo_prod_ff[ch]) + ROUND_HALF;
         end
         g_chan_in[ch] = round_sum[FRACTION_BITS +: CHAN_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else begin
         g_valid_ff <= f_valid_ff;
      end
      g_rainbow_ff <= f_rainbow_ff;
      g_chan_ff    <= g_chan_in;
   end

   assign rsp_strobe = g_valid_ff;
   assign rsp_red    = g_chan_ff[0];
   assign rsp_green  = g_chan_ff[1];
   assign rsp_blue   = g_chan_ff[2];

`ifndef SYNTHESIS
   // every word comes from a sample accepted a fixed depth earlier
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, PIPE_DEPTH))
      else $error("result strobe without an accepted sample");

   // every accepted sample yields its word a fixed depth later
   a_no_lost_word: assert property (@(posedge clock) disable iff (reset)
      $past(start && !busy, PIPE_DEPTH) |-> rsp_strobe)
      else $error("accepted sample produced no result strobe");

   // the hue ramp always has one channel at full and one at zero
   a_rainbow_extremes: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && g_rainbow_ff) |->
         ((rsp_red == CHAN_FULL || rsp_green == CHAN_FULL || rsp_blue == CHAN_FULL) &&
          (rsp_red == CHAN_NONE || rsp_green == CHAN_NONE || rsp_blue == CHAN_NONE)))
      else $error("rainbow color lacks a full or an empty channel");

   // forced results leave the divider with no quotient bits set
   a_forced_quotient: assert property (@(posedge clock) disable iff (reset)
      (div_valid_ff[FRACTION_BITS] && div_kind_ff[FRACTION_BITS] != NK_DIV) |->
         (div_quo_ff[FRACTION_BITS] == '0))
      else $error("divider produced quotient bits for a clamped sample");
`endif

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench of scalar_to_color_map_unit: rainbow and gradient colors.
`timescale 1ns / 100ps

module testbench;
   import s2cm_pkg::*;

   localparam longint unsigned UNIT = 64'd1 << FRACTION_BITS;
   localparam int LIMIT = 300000;
   localparam int ROUNDS = 12;
   localparam int ROUND_ITEMS = 125;

   // csr indexes past the end of the register list, which the block ignores
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [CHAN_BITS-1:0] red;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] blue;
   } rgb_word_type;

   class rgb_checker;
      longint lo_bound;
      longint hi_bound;
      bit rainbow_on;
      bit rainbow_rev;
      logic [COLOR_BITS-1:0] low_rgb;
      logic [COLOR_BITS-1:0] high_rgb;
      rgb_word_type pending_colors[$];
      int colors_checked;
      int regs_written;
      int errors;

      function new();
         lo_bound = 0;
         hi_bound = 65536;
         rainbow_on = 1'b1;
         rainbow_rev = 1'b0;
         low_rgb = 24'h000000;
         high_rgb = 24'hFFFFFF;
         colors_checked = 0;
         regs_written = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         regs_written++;
         case (idx)
            CSR_RANGE_MIN:      lo_bound = longint'($signed(data));
            CSR_RANGE_MAX:      hi_bound = longint'($signed(data));
            CSR_RAINBOW_ENABLE: rainbow_on = data[0];
            CSR_RAINBOW_INVERT: rainbow_rev = data[0];
            CSR_LOW_COLOR:      low_rgb = data[COLOR_BITS-1:0];
            CSR_HIGH_COLOR:     high_rgb = data[COLOR_BITS-1:0];
            default: ;
         endcase
      endfunction

      function logic [CHAN_BITS-1:0] chan8(longint unsigned c);
         return CHAN_BITS'((c * 255 + UNIT / 2) >> FRACTION_BITS);
      endfunction

      function logic [CHAN_BITS-1:0] mix(longint unsigned lo, longint unsigned hi,
                                         longint unsigned norm);
         return CHAN_BITS'((hi * norm + lo * (UNIT - norm) + UNIT / 2) >> FRACTION_BITS);
      endfunction

      function rgb_word_type predict_color(logic signed [SAMPLE_BITS-1:0] s);
         longint d, r;
         longint unsigned ad, ar, norm, t, p, q, n, rc, gc, bc;
         logic [2:0] seg;
         rgb_word_type c;
         d = longint'(s) - lo_bound;
         r = hi_bound - lo_bound;
         // zero range, zero offset or opposite signs all land on normalized zero
         if (r == 0 || d == 0 || ((d < 0) != (r < 0))) begin
            norm = 0;
         end else begin
            ad = (d < 0) ? -d : d;
            ar = (r < 0) ? -r : r;
            norm = (ad >= ar) ? UNIT : (ad << FRACTION_BITS) / ar;
         end
         if (rainbow_on) begin
            t = rainbow_rev ? norm : UNIT - norm;
            p = t * 5;
            seg = 3'(p >> FRACTION_BITS);
            q = p & (UNIT - 1);
            n = seg[0] ? q : UNIT - q;
            case (seg)
               SEG_MAGENTA_BLUE: begin rc = n;    gc = 0;    bc = UNIT; end
               SEG_BLUE_CYAN:    begin rc = 0;    gc = n;    bc = UNIT; end
               SEG_CYAN_GREEN:   begin rc = 0;    gc = UNIT; bc = n;    end
               SEG_GREEN_YELLOW: begin rc = n;    gc = UNIT; bc = 0;    end
               default:          begin rc = UNIT; gc = n;    bc = 0;    end
            endcase
            c.red = chan8(rc);
            c.green = chan8(gc);
            c.blue = chan8(bc);
         end else begin
            c.red = mix(low_rgb[23:16], high_rgb[23:16], norm);
            c.green = mix(low_rgb[15:8], high_rgb[15:8], norm);
            c.blue = mix(low_rgb[7:0], high_rgb[7:0], norm);
         end
         return c;
      endfunction

      function void note_sample(logic signed [SAMPLE_BITS-1:0] s);
         pending_colors.insert(pending_colors.size(), predict_color(s));
      endfunction

      function void check_color(rgb_word_type got);
         rgb_word_type want;
         if (pending_colors.size() == 0) begin
            errors++;
            $display("%0t: color word with none pending: got %06h", $time, got);
            return;
         end
         want = pending_colors.pop_front();
         colors_checked++;
         if (got.red !== want.red) begin
            errors++;
            $display("%0t: red mismatch: expected %02h, actual %02h", $time, want.red, got.red);
         end
         if (got.green !== want.green) begin
            errors++;
            $display("%0t: green mismatch: expected %02h, actual %02h", $time, want.green,
                     got.green);
         end
         if (got.blue !== want.blue) begin
            errors++;
            $display("%0t: blue mismatch: expected %02h, actual %02h", $time, want.blue,
                     got.blue);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic signed [SAMPLE_BITS-1:0] req_sample;
   logic rsp_strobe;
   logic [CHAN_BITS-1:0] rsp_red;
   logic [CHAN_BITS-1:0] rsp_green;
   logic [CHAN_BITS-1:0] rsp_blue;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;

   rgb_checker sb = new();
   int idle_pct;
   int cycle_count;

   scalar_to_color_map_unit dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_sample(req_sample),
      .rsp_strobe(rsp_strobe),
      .rsp_red(rsp_red),
      .rsp_green(rsp_green),
      .rsp_blue(rsp_blue),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // every handshake is observed here; the checker's register copy follows the csr port
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_sample(req_sample);
         if (rsp_strobe) sb.check_color({rsp_red, rsp_green, rsp_blue});
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
      end
   end

   // entered and left at a falling edge; start stays high into the next call
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         req_sample = $urandom;
         @(negedge clock);
      end
      start = 1'b1;
      req_sample = s;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // drain the pipeline so registers can change safely
   task automatic quiesce();
      start = 1'b0;
      while (sb.pending_colors.size() != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 2) @(negedge clock);
   endtask

   task automatic set_regs(input logic [31:0] mn, input logic [31:0] mx, input logic ren,
                           input logic rinv, input logic [23:0] lo, input logic [23:0] hi);
      quiesce();
      csr_write(CSR_RANGE_MIN, mn);
      csr_write(CSR_RANGE_MAX, mx);
      csr_write(CSR_RAINBOW_ENABLE, {31'($urandom), ren});
      csr_write(CSR_RAINBOW_INVERT, {31'($urandom), rinv});
      csr_write(CSR_LOW_COLOR, {8'($urandom), lo});
      csr_write(CSR_HIGH_COLOR, {8'($urandom), hi});
   endtask

   initial begin
      int rnd, i, k, lo_i;
      longint span, v;
      logic [31:0] mn, mx;
      reset = 1'b1;
      start = 1'b0;
      req_sample = '0;
      csr_valid = 1'b0;
      csr_index = CSR_RANGE_MIN;
      csr_data = '0;
      idle_pct = 0;
      cycle_count = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: field extremes and hue segment boundaries
      send_sample(0);
      send_sample(65536);
      send_sample(65537);
      send_sample(-1);
      send_sample(32'sh7FFFFFFF);
      send_sample(32'sh80000000);
      send_sample(13107);
      send_sample(13108);
      send_sample(26214);
      send_sample(32768);
      send_sample(39321);
      send_sample(52428);
      send_sample(52429);

      set_regs(-1000, 1000, 1'b1, 1'b1, 24'h000000, 24'hFFFFFF);
      send_sample(-1000);
      send_sample(1000);
      send_sample(0);

      // zero range; spare indexes must not disturb anything
      set_regs(12345, 12345, 1'b1, 1'b0, 24'h000000, 24'hFFFFFF);
      csr_write(CSR_SPARE_LO, 32'hFFFFFFFF);
      csr_write(CSR_SPARE_HI, 32'h5A5A5A5A);
      send_sample(12345);
      send_sample(0);

      // inverted range: samples below range_min head toward one
      set_regs(5000, -5000, 1'b1, 1'b0, 24'h000000, 24'hFFFFFF);
      send_sample(5000);
      send_sample(-5000);
      send_sample(6000);
      send_sample(0);

      set_regs(32'h80000000, 32'h7FFFFFFF, 1'b0, 1'b1, 24'h123456, 24'hABCDEF);
      send_sample(32'sh80000000);
      send_sample(32'sh7FFFFFFF);
      send_sample(0);

      for (rnd = 0; rnd < ROUNDS; rnd++) begin
         case (rnd)
            0: set_regs(32'h80000000, 32'h7FFFFFFF, 1'b1, 1'b0, 24'h000000, 24'hFFFFFF);
            1: set_regs(32'h7FFFFFFF, 32'h80000000, 1'b1, 1'b1, 24'h000000, 24'hFFFFFF);
            2: set_regs(-65536, 65536, 1'b0, 1'b0, 24'h000000, 24'hFFFFFF);
            3: set_regs(0, 255, 1'b0, 1'b1, 24'hFFFFFF, 24'h000000);
            default: begin
               case ($urandom_range(3))
                  0: begin
                     mn = $urandom;
                     mx = $urandom;
                  end
                  1: begin
                     lo_i = int'($urandom_range(140000)) - 70000;
                     mn = lo_i;
                     mx = lo_i + int'($urandom_range(100000)) - 20000;
                  end
                  2: begin
                     mn = $urandom;
                     mx = mn;
                  end
                  default: begin
                     mn = $urandom_range(1) ? 32'h80000000 : 32'h7FFFFFFF;
                     mx = ~mn;
                  end
               endcase
               set_regs(mn, mx, 1'($urandom), 1'($urandom), 24'($urandom), 24'($urandom));
            end
         endcase
         case (rnd % 3)
            0: idle_pct = 0;
            1: idle_pct = 87;
            default: idle_pct = 33;
         endcase
         span = sb.hi_bound - sb.lo_bound;
         for (i = 0; i < ROUND_ITEMS; i++) begin
            case ($urandom_range(9))
               0, 1: v = longint'($signed(32'($urandom)));
               2: v = sb.lo_bound;
               3: v = sb.hi_bound;
               default: begin
                  // mostly inside the range, with some overshoot on both ends
                  k = int'($urandom_range(1224)) - 100;
                  v = sb.lo_bound + (span * k) / 1024;
                  if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
                  if (v < -64'sh80000000) v = -64'sh80000000;
               end
            endcase
            send_sample(SAMPLE_BITS'(v));
         end
      end

      quiesce();
      $display("checked %0d colors against the predictor, %0d register writes,",
               sb.colors_checked, sb.regs_written);
      $display("rainbow and gradient modes over zero, inverted and full-scale ranges");
      if (sb.errors == 0 && sb.pending_colors.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
